// File: design/bps_pkg.sv
// types and constants shared by the bilinear pixel sampler
// no dependencies
`timescale 1ns / 1ps

package bps_pkg;

    typedef logic [1:0] bps_cfg_index_t;

    localparam bps_cfg_index_t CFG_IMAGE_WIDTH   = 2'd0;
    localparam bps_cfg_index_t CFG_IMAGE_HEIGHT  = 2'd1;
    localparam bps_cfg_index_t CFG_CHANNEL_COUNT = 2'd2;
    localparam bps_cfg_index_t CFG_TOP_DOWN      = 2'd3;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // 1.0 in the 8-bit fraction format
    localparam logic [8:0] FRAC_ONE = 9'd256;

    localparam int NUM_BANKS = 4;

    // parity bits of the two rows and two columns of a sample
    typedef struct packed {
        logic r1;
        logic r2;
        logic x1;
        logic x2;
    } bps_tap_sel_t;

    typedef struct packed {
        logic [8:0] fx;
        logic [8:0] gx;
        logic [8:0] fy;
        logic [8:0] gy;
    } bps_weights_t;

endpackage

// File: design/bilinear_pixel_sampler_core.sv
// bilinear pixel sampler: image store in four row/column parity banks and a weighting pipeline
// depends on bps_pkg
// a sample result is registered at the bank read, the horizontal weighting and the output
// one transaction per cycle unless stalled, writes and samples mixed, one read per parity bank
// reset: asynchronous, clears pipeline valid flags and presets the configuration registers;
// the image store is not cleared and holds undefined data until written
`timescale 1ns / 1ps

module bilinear_pixel_sampler_core #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [8:0]  column,
    input  logic [8:0]  line,
    input  logic [8:0]  frac_x,
    input  logic [8:0]  frac_y,
    input  logic [31:0] pixel_word,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_out
);

    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    function automatic logic [AW-1:0] bank_addr(input logic [8:0] row, input logic [8:0] col);
        return AW'(32'(row[8:1]) * 32'(HALF_W) + 32'(col[8:1]));
    endfunction

    // configuration
    logic [8:0] image_width_reg;
    logic [8:0] image_height_reg;
    logic [2:0] channel_count_reg;
    logic       top_down_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 9'd256;
            image_height_reg  <= 9'd256;
            channel_count_reg <= 3'd1;
            top_down_reg      <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bps_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                bps_pkg::CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                bps_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[2:0];
                bps_pkg::CFG_TOP_DOWN:      top_down_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic mem_v_reg, mem_v_next;
    logic prod_v_reg, prod_v_next;
    logic out_v_reg, out_v_next;
    logic en_out, en_prod, en_mem;
    logic in_accept;

    assign en_out    = !out_v_reg || !out_stall;
    assign en_prod   = !prod_v_reg || en_out;
    assign en_mem    = !mem_v_reg || en_prod;
    assign in_stall  = !en_mem;
    assign in_accept = in_valid && en_mem;

    // address generation
    logic [8:0] w_eff, h_eff;
    logic [2:0] nch;
    logic [8:0] x1, x2, y1, y2, r1, r2;
    logic [9:0] line_inc;
    logic       col_inside;
    logic [MAX_CHANNELS-1:0] ch_mask_next;
    bps_pkg::bps_weights_t   wts_next;
    bps_pkg::bps_tap_sel_t   sel_next;
    logic [AW-1:0] rd_addr [bps_pkg::NUM_BANKS];
    logic          wr_en;
    logic [1:0]    wr_bank;
    logic [AW-1:0] wr_addr;

    always_comb
    begin
        if (image_width_reg == 9'd0)
            w_eff = 9'd1;
        else if (32'(image_width_reg) > MAX_WIDTH)
            w_eff = 9'(MAX_WIDTH);
        else
            w_eff = image_width_reg;

        if (image_height_reg == 9'd0)
            h_eff = 9'd1;
        else if (32'(image_height_reg) > MAX_HEIGHT)
            h_eff = 9'(MAX_HEIGHT);
        else
            h_eff = image_height_reg;

        if (channel_count_reg == 3'd0)
            nch = 3'd1;
        else if (32'(channel_count_reg) > MAX_CHANNELS)
            nch = 3'(MAX_CHANNELS);
        else
            nch = channel_count_reg;

        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            ch_mask_next[c] = (3'(c) < nch);
        end

        wts_next.fx = (frac_x > bps_pkg::FRAC_ONE) ? bps_pkg::FRAC_ONE : frac_x;
        wts_next.fy = (frac_y > bps_pkg::FRAC_ONE) ? bps_pkg::FRAC_ONE : frac_y;
        wts_next.gx = bps_pkg::FRAC_ONE - wts_next.fx;
        wts_next.gy = bps_pkg::FRAC_ONE - wts_next.fy;

        col_inside = column < (w_eff - 9'd1);
        x1 = col_inside ? column : (w_eff - 9'd1);
        x2 = col_inside ? (x1 + 9'd1) : x1;
        y1 = (line < (h_eff - 9'd1)) ? line : (h_eff - 9'd1);
        line_inc = {1'b0, line} + 10'd1;
        y2 = (line_inc < {1'b0, h_eff - 9'd1}) ? line_inc[8:0] : (h_eff - 9'd1);

        if (top_down_reg)
        begin
            r1 = y1;
            r2 = y2;
        end
        else
        begin
            r1 = h_eff - 9'd1 - y1;
            r2 = h_eff - 9'd1 - y2;
        end

        sel_next.r1 = r1[0];
        sel_next.r2 = r2[0];
        sel_next.x1 = x1[0];
        sel_next.x2 = x2[0];

        for (int b = 0; b < bps_pkg::NUM_BANKS; b++)
        begin
            rd_addr[b] = bank_addr((r1[0] == 1'(b / 2)) ? r1 : r2,
                                   (x1[0] == 1'(b % 2)) ? x1 : x2);
        end

        wr_en   = in_accept && (kind == bps_pkg::KIND_WRITE)
                  && (32'(column) < MAX_WIDTH) && (32'(line) < MAX_HEIGHT);
        wr_bank = {line[0], column[0]};
        wr_addr = bank_addr(line, column);
    end

    // parity banks
    logic [31:0] bank_q [bps_pkg::NUM_BANKS];

    for (genvar b = 0; b < bps_pkg::NUM_BANKS; b++)
    begin : g_bank
        logic [31:0] mem [BANK_DEPTH];
        logic [31:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(b)))
                mem[wr_addr] <= pixel_word;
            if (en_mem)
                q_reg <= mem[rd_addr[b]];
        end

        assign bank_q[b] = q_reg;
    end

    // sideband alongside the memory read
    bps_pkg::bps_weights_t   wts_reg;
    bps_pkg::bps_tap_sel_t   sel_reg;
    logic [MAX_CHANNELS-1:0] mem_mask_reg;

    always_ff @(posedge clk)
    begin
        if (en_mem)
        begin
            wts_reg      <= wts_next;
            sel_reg      <= sel_next;
            mem_mask_reg <= ch_mask_next;
        end
    end

    // horizontal weighting
    logic [31:0] p00, p01, p10, p11;
    logic [15:0] top_next [MAX_CHANNELS];
    logic [15:0] bot_next [MAX_CHANNELS];
    logic [15:0] top_reg [MAX_CHANNELS];
    logic [15:0] bot_reg [MAX_CHANNELS];
    logic [8:0]  fy_reg, gy_reg;
    logic [MAX_CHANNELS-1:0] prod_mask_reg;

    always_comb
    begin
        p00 = bank_q[{sel_reg.r1, sel_reg.x1}];
        p01 = bank_q[{sel_reg.r1, sel_reg.x2}];
        p10 = bank_q[{sel_reg.r2, sel_reg.x1}];
        p11 = bank_q[{sel_reg.r2, sel_reg.x2}];
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            top_next[c] = 16'(17'(wts_reg.gx) * 17'(p00[8*c +: 8])
                            + 17'(wts_reg.fx) * 17'(p01[8*c +: 8]));
            bot_next[c] = 16'(17'(wts_reg.gx) * 17'(p10[8*c +: 8])
                            + 17'(wts_reg.fx) * 17'(p11[8*c +: 8]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            top_reg       <= top_next;
            bot_reg       <= bot_next;
            fy_reg        <= wts_reg.fy;
            gy_reg        <= wts_reg.gy;
            prod_mask_reg <= mem_mask_reg;
        end
    end

    // vertical weighting and truncation
    logic [31:0] pixel_next;
    logic [31:0] pixel_reg;
    logic [24:0] vsum [MAX_CHANNELS];

    always_comb
    begin
        pixel_next = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            vsum[c] = 25'(gy_reg) * 25'(top_reg[c]) + 25'(fy_reg) * 25'(bot_reg[c]);
            if (prod_mask_reg[c])
                pixel_next[8*c +: 8] = vsum[c][23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
            pixel_reg <= pixel_next;
    end

    always_comb
    begin
        mem_v_next  = en_mem  ? (in_accept && (kind == bps_pkg::KIND_SAMPLE)) : mem_v_reg;
        prod_v_next = en_prod ? mem_v_reg : prod_v_reg;
        out_v_next  = en_out  ? prod_v_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            mem_v_reg  <= mem_v_next;
            prod_v_reg <= prod_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    assign out_valid = out_v_reg;
    assign pixel_out = pixel_reg;

    // assertions
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (mem_v_reg && prod_v_reg && out_v_reg))
        else $error("input stalled with a free pipeline stage");

    a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == bps_pkg::KIND_SAMPLE) |=> mem_v_reg)
        else $error("accepted sample lost at memory stage");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == bps_pkg::KIND_WRITE) |=> !mem_v_reg)
        else $error("write transaction produced a result");

    a_result_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_v_reg && !(out_valid && out_stall)) |=> out_valid)
        else $error("weighted result not moved to output");

endmodule

// File: verif/bps_sample_checker.sv
// checker for the bilinear pixel sampler: keeps its own image copy and format registers,
// predicts each sampled pixel and compares it with pixel_out in order
// depends on bps_pkg
`timescale 1ns / 1ps

module bps_sample_checker #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [8:0]  column,
    input  logic [8:0]  line,
    input  logic [8:0]  frac_x,
    input  logic [8:0]  frac_y,
    input  logic [31:0] pixel_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] pixel_out,
    output int          mismatch_count,
    output int          results_pending
);

    logic [31:0] image_copy [MAX_WIDTH*MAX_HEIGHT];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [2:0]  channels_reg;
    logic        top_down_reg;
    logic [31:0] expected_pixels [$];
    logic [31:0] oldest_pixel;

    initial
    begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    function automatic logic [31:0] interpolate_pixel(input logic [8:0] col, input logic [8:0] ln,
                                                      input logic [8:0] fx_in,
                                                      input logic [8:0] fy_in);
        int          w, h, nch, x1, x2, y1, y2, row1, row2, c;
        logic [8:0]  fx, fy, gx, gy;
        logic [31:0] p00, p01, p10, p11, pix;
        logic [16:0] upper, lower;
        logic [24:0] acc;
        w   = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h   = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        nch = (channels_reg == 0) ? 1 : (channels_reg > MAX_CHANNELS) ? MAX_CHANNELS : channels_reg;
        fx  = (fx_in > bps_pkg::FRAC_ONE) ? bps_pkg::FRAC_ONE : fx_in;
        fy  = (fy_in > bps_pkg::FRAC_ONE) ? bps_pkg::FRAC_ONE : fy_in;
        gx  = bps_pkg::FRAC_ONE - fx;
        gy  = bps_pkg::FRAC_ONE - fy;
        x1  = (col < w - 1) ? col : w - 1;
        x2  = (col < w - 1) ? x1 + 1 : x1;
        y1  = (ln < h - 1) ? ln : h - 1;
        y2  = (ln + 1 < h - 1) ? ln + 1 : h - 1;
        row1 = top_down_reg ? y1 : h - 1 - y1;
        row2 = top_down_reg ? y2 : h - 1 - y2;
        p00 = image_copy[row1*MAX_WIDTH + x1];
        p01 = image_copy[row1*MAX_WIDTH + x2];
        p10 = image_copy[row2*MAX_WIDTH + x1];
        p11 = image_copy[row2*MAX_WIDTH + x2];
        pix = '0;
        for (c = 0; c < nch; c++)
        begin
            upper = gx * p00[8*c +: 8] + fx * p01[8*c +: 8];
            lower = gx * p10[8*c +: 8] + fx * p11[8*c +: 8];
            acc   = gy * upper + fy * lower;
            pix[8*c +: 8] = acc[23:16];
        end
        return pix;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    = 9'd256;
            height_reg   = 9'd256;
            channels_reg = 3'd1;
            top_down_reg = 1'b1;
            expected_pixels.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel_out: expected none, actual %h", pixel_out);
                    mismatch_count++;
                end
                else
                begin
                    oldest_pixel = expected_pixels.pop_front();
                    if (pixel_out !== oldest_pixel)
                    begin
                        $error("pixel_out: expected %h, actual %h", oldest_pixel, pixel_out);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    bps_pkg::CFG_IMAGE_WIDTH:   width_reg    = cfg_data;
                    bps_pkg::CFG_IMAGE_HEIGHT:  height_reg   = cfg_data;
                    bps_pkg::CFG_CHANNEL_COUNT: channels_reg = cfg_data[2:0];
                    bps_pkg::CFG_TOP_DOWN:      top_down_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (kind == bps_pkg::KIND_WRITE)
                begin
                    if (column < MAX_WIDTH && line < MAX_HEIGHT)
                        image_copy[line*MAX_WIDTH + column] = pixel_word;
                end
                else
                    expected_pixels.push_back(interpolate_pixel(column, line, frac_x, frac_y));
            end
        end
        results_pending = expected_pixels.size();
    end

endmodule

// File: verif/bilinear_pixel_sampler_core_tb.sv
// testbench top for bilinear_pixel_sampler_core: clock, reset, format writes, pixel
// writes and samples with random idling and stalls; verdict from bps_sample_checker
// depends on bps_pkg, bilinear_pixel_sampler_core and bps_sample_checker
`timescale 1ns / 1ps

module bilinear_pixel_sampler_core_tb;

    localparam int MAX_WIDTH      = 256;
    localparam int MAX_HEIGHT     = 256;
    localparam int MAX_CHANNELS   = 4;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int BATCH_ITEMS    = 150;
    localparam int NUM_BATCHES    = 12;
    localparam int HOLDOFF_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [8:0]  column;
    logic [8:0]  line;
    logic [8:0]  frac_x;
    logic [8:0]  frac_y;
    logic [31:0] pixel_word;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] pixel_out;

    int mismatch_count;
    int results_pending;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_stall_pct;
    bit holdoff_req = 1'b0;
    int eff_width;
    int eff_height;
    bit eff_top_down;
    int batch_sent;
    int batch;
    bit pixel_written [MAX_WIDTH*MAX_HEIGHT];

    always #4 clk = ~clk;

    bilinear_pixel_sampler_core #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .column     (column),
        .line       (line),
        .frac_x     (frac_x),
        .frac_y     (frac_y),
        .pixel_word (pixel_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out)
    );

    bps_sample_checker #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) sample_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .column          (column),
        .line            (line),
        .frac_x          (frac_x),
        .frac_y          (frac_y),
        .pixel_word      (pixel_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pixel_out       (pixel_out),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                repeat (HOLDOFF_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [8:0] rand_frac();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return bps_pkg::FRAC_ONE;
            2:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_position(input int extent);
        case ($urandom_range(0, 9))
            0:       return extent - 1;
            1:       return $urandom_range(extent, 511);
            2:       return 0;
            default: return $urandom_range(0, (extent > 16) ? 15 : extent - 1);
        endcase
    endfunction

    task automatic send_transaction(input logic k, input int col, input int ln,
                                    input logic [8:0] fx, input logic [8:0] fy,
                                    input logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        column     <= col[8:0];
        line       <= ln[8:0];
        frac_x     <= fx;
        frac_y     <= fy;
        pixel_word <= word;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        batch_sent++;
    endtask

    task automatic store_pixel(input int col, input int row, input logic [31:0] word);
        send_transaction(bps_pkg::KIND_WRITE, col, row, rand_frac(), rand_frac(), word);
        if (col < MAX_WIDTH && row < MAX_HEIGHT)
            pixel_written[row*MAX_WIDTH + col] = 1'b1;
    endtask

    // writes any of the four neighbours not yet stored, then samples
    task automatic sample_pixel(input int col, input int ln, input logic [8:0] fx,
                                input logic [8:0] fy);
        int xa, ya, yb, i, j;
        int rows[2];
        int cols[2];
        xa      = (col < eff_width - 1) ? col : eff_width - 1;
        cols[0] = xa;
        cols[1] = (col < eff_width - 1) ? xa + 1 : xa;
        ya      = (ln < eff_height - 1) ? ln : eff_height - 1;
        yb      = (ln + 1 < eff_height - 1) ? ln + 1 : eff_height - 1;
        rows[0] = eff_top_down ? ya : eff_height - 1 - ya;
        rows[1] = eff_top_down ? yb : eff_height - 1 - yb;
        for (i = 0; i < 2; i++)
            for (j = 0; j < 2; j++)
                if (!pixel_written[rows[i]*MAX_WIDTH + cols[j]])
                    store_pixel(cols[j], rows[i], rand_word());
        send_transaction(bps_pkg::KIND_SAMPLE, col, ln, fx, fy, rand_word());
    endtask

    task automatic apply_image_format(input logic [8:0] w, input logic [8:0] h,
                                      input logic [2:0] nch, input logic td);
        cfg_write <= 1'b1;
        cfg_index <= bps_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= bps_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= bps_pkg::CFG_CHANNEL_COUNT;
        cfg_data  <= {6'd0, nch};
        @(negedge clk);
        cfg_index <= bps_pkg::CFG_TOP_DOWN;
        cfg_data  <= {8'd0, td};
        @(negedge clk);
        cfg_write <= 1'b0;
        eff_width    = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        eff_height   = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        eff_top_down = td;
    endtask

    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_batch(input bit with_holdoff);
        int col, row;
        bit holdoff_asked;
        holdoff_asked = 1'b0;
        batch_sent = 0;
        while (batch_sent < BATCH_ITEMS)
        begin
            if (with_holdoff && !holdoff_asked && batch_sent >= 40)
            begin
                holdoff_req   = 1'b1;
                holdoff_asked = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        col = $urandom_range(256, 511);
                        row = $urandom_range(0, 511);
                    end
                    1:
                    begin
                        col = $urandom_range(0, 255);
                        row = $urandom_range(256, 511);
                    end
                    2:
                    begin
                        col = $urandom_range(0, 255);
                        row = $urandom_range(0, 255);
                    end
                    default:
                    begin
                        col = pick_position(eff_width);
                        row = pick_position(eff_height);
                        if (!eff_top_down && row < eff_height)
                            row = eff_height - 1 - row;
                    end
                endcase
                store_pixel(col, row, rand_word());
            end
            else
                sample_pixel(pick_position(eff_width), pick_position(eff_height),
                             rand_frac(), rand_frac());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = bps_pkg::CFG_IMAGE_WIDTH;
        cfg_data       = 9'd0;
        in_valid       = 1'b0;
        kind           = bps_pkg::KIND_WRITE;
        column         = 9'd0;
        line           = 9'd0;
        frac_x         = 9'd0;
        frac_y         = 9'd0;
        pixel_word     = 32'd0;
        send_idle_pct  = 6;
        recv_stall_pct = 87;
        eff_width      = MAX_WIDTH;
        eff_height     = MAX_HEIGHT;
        eff_top_down   = 1'b1;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset format: full image, one channel, top-down
        store_pixel(256, 0, rand_word());
        store_pixel(0, 256, rand_word());
        store_pixel(511, 511, 32'hFFFF_FFFF);
        store_pixel(0, 0, 32'hFFFF_FFFF);
        store_pixel(1, 0, 32'h0000_0000);
        store_pixel(0, 1, 32'h8040_2010);
        store_pixel(1, 1, 32'h0102_04FF);
        sample_pixel(0, 0, 9'd0, 9'd0);
        sample_pixel(0, 0, bps_pkg::FRAC_ONE, bps_pkg::FRAC_ONE);
        sample_pixel(0, 0, 9'd511, 9'd300);
        sample_pixel(0, 0, 9'd128, 9'd64);
        sample_pixel(255, 255, 9'd255, 9'd1);
        sample_pixel(300, 400, 9'd100, 9'd200);
        sample_pixel(511, 511, bps_pkg::FRAC_ONE, 9'd0);
        sample_pixel(254, 254, 9'd170, 9'd85);
        settle_pipeline();

        for (batch = 0; batch < NUM_BATCHES; batch++)
        begin
            case (batch)
                0:       apply_image_format(9'd4, 9'd3, 3'd4, 1'b0);
                1:       apply_image_format(9'd1, 9'd1, 3'd2, 1'b1);
                2:       apply_image_format(9'd0, 9'd0, 3'd0, 1'b0);
                3:       apply_image_format(9'd300, 9'd511, 3'd7, 1'b1);
                4:       apply_image_format(9'd256, 9'd2, 3'd4, 1'b0);
                5:       apply_image_format(9'd2, 9'd256, 3'd3, 1'b1);
                6:       apply_image_format(9'd256, 9'd256, 3'd4, 1'b0);
                default: apply_image_format(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                                            3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            endcase
            if (batch < 4)
            begin
                send_idle_pct  = 6;
                recv_stall_pct = 87;
            end
            else if (batch < 8)
            begin
                send_idle_pct  = 87;
                recv_stall_pct = 6;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            random_batch(batch == 9);
            settle_pipeline();
        end

        if (mismatch_count == 0 && results_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
design/bps_pkg.sv
design/bilinear_pixel_sampler_core.sv
verif/bps_sample_checker.sv
verif/bilinear_pixel_sampler_core_tb.sv
